### hw/rtl/angsp_pkg.sv
// ----------------------------------------------------------------------------
// angsp_pkg: shared types and constants for the angular spring moment unit
// Field widths, configuration register codes and reset values.
// ----------------------------------------------------------------------------
package angsp_pkg;

  localparam int NumAxes    = 3;
  localparam int EntryW     = 16;   // Q2.14 rotation entry / Q8.8 rate
  localparam int ColW       = 48;   // packed reference column
  localparam int CoefW      = 24;   // unsigned Q16.8 coefficient
  localparam int MomentW    = 32;   // Q24.8 moment
  localparam int InDataW    = 192;  // 12 x 16-bit fields
  localparam int OutDataW   = 96;   // 3 x 32-bit fields
  localparam int CfgIndexW  = 3;
  localparam int CfgDataW   = 48;

  // internal precision of the datapath
  localparam int DotW       = 33;   // sum of three 16x16 products
  localparam int ProjW      = 48;   // dot times reference entry
  localparam int RemW       = 20;   // remainder vector entry, Q14
  localparam int CrossW     = 36;   // reference entry times remainder
  localparam int SumW       = 38;   // summed crosses, Q28
  localparam int SplitW     = 19;   // half of SumW for the stiffness product
  localparam int SprLoW     = 43;
  localparam int SprHiW     = 44;
  localparam int SpringW    = 36;
  localparam int DampPW     = 40;
  localparam int DampW      = 33;
  localparam int TotalW     = 38;

  localparam logic [ColW-1:0] RefColXReset = 48'h0000_0000_4000;
  localparam logic [ColW-1:0] RefColYReset = 48'h0000_4000_0000;
  localparam logic [ColW-1:0] RefColZReset = 48'h4000_0000_0000;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_REF_COL_X = 3'd0,
    CFG_REF_COL_Y = 3'd1,
    CFG_REF_COL_Z = 3'd2,
    CFG_STIFFNESS = 3'd3,
    CFG_DAMPING   = 3'd4
  } cfg_index_t;

endpackage

### hw/rtl/angular_spring_restoring_moment_unit.sv
// ----------------------------------------------------------------------------
// angular_spring_restoring_moment_unit: spring/damper restoring moment
// Spherical angular spring with damping on a Q2.14 rotation and Q8.8 rate,
// Q24.8 saturated moment out.
// ----------------------------------------------------------------------------
// A request passes stage registers 1 to 8; stage 8 is the output register.
// Throughput: one request per cycle unless the output stalls, set by the
//   eight-stage multiply/add pipeline, each stage at most one multiplier deep.
// Reset (rst, synchronous): pipeline valid bits clear, reference columns
//   return to identity, stiffness and damping to zero.
module angular_spring_restoring_moment_unit (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // low to high: rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz,
  //   rot_zx, rot_zy, rot_zz, omega_x, omega_y, omega_z (16 bits each)
  input  logic [angsp_pkg::InDataW-1:0]       s_axis_tdata,
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // low to high: moment_x, moment_y, moment_z (32 bits each)
  output logic [angsp_pkg::OutDataW-1:0]      m_axis_tdata,
  // bit 0: saturated
  output logic [0:0]                          m_axis_tuser,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [angsp_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [angsp_pkg::CfgDataW-1:0]      cfg_data
);

  localparam int NA     = angsp_pkg::NumAxes;
  localparam int EW     = angsp_pkg::EntryW;
  localparam int NStage = 8;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [angsp_pkg::ColW-1:0]  ref_col [NA];
  logic [angsp_pkg::CoefW-1:0] stiffness;
  logic [angsp_pkg::CoefW-1:0] damping;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_col[0] <= angsp_pkg::RefColXReset;
      ref_col[1] <= angsp_pkg::RefColYReset;
      ref_col[2] <= angsp_pkg::RefColZReset;
      stiffness  <= '0;
      damping    <= '0;
    end else if (cfg_we) begin
      unique case (angsp_pkg::cfg_index_t'(cfg_index))
        angsp_pkg::CFG_REF_COL_X: ref_col[0] <= cfg_data;
        angsp_pkg::CFG_REF_COL_Y: ref_col[1] <= cfg_data;
        angsp_pkg::CFG_REF_COL_Z: ref_col[2] <= cfg_data;
        angsp_pkg::CFG_STIFFNESS: stiffness  <= cfg_data[angsp_pkg::CoefW-1:0];
        angsp_pkg::CFG_DAMPING:   damping    <= cfg_data[angsp_pkg::CoefW-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // q[col][comp]: reference entries, signed Q2.14
  logic signed [EW-1:0] q [NA][NA];
  always_comb begin
    for (int c = 0; c < NA; c++) begin
      for (int i = 0; i < NA; i++) begin
        q[c][i] = $signed(ref_col[c][EW*i +: EW]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: each stage loads when empty or when the stage after it
  // moves, so bubbles collapse and a stall only backs up as far as needed.
  // --------------------------------------------------------------------------
  logic [NStage:1] vld;
  logic [NStage:1] en;

  always_comb begin
    en[NStage] = !vld[NStage] || m_axis_tready;
    for (int s = NStage - 1; s >= 1; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  assign s_axis_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_axis_tvalid;
      end
      for (int s = 2; s <= NStage; s++) begin
        if (en[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input unpack: r[row][col]
  // --------------------------------------------------------------------------
  logic signed [EW-1:0] r_in [NA][NA];
  logic signed [EW-1:0] w_in [NA];
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int c = 0; c < NA; c++) begin
        r_in[i][c] = $signed(s_axis_tdata[EW*(NA*i+c) +: EW]);
      end
      w_in[i] = $signed(s_axis_tdata[EW*(NA*NA+i) +: EW]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: for axis k, n = column k+1 of R, dot d = a.n with a = Q column k
  // --------------------------------------------------------------------------
  logic signed [angsp_pkg::DotW-1:0] d1 [NA];
  logic signed [EW-1:0]              n1 [NA][NA];
  logic signed [EW-1:0]              w1 [NA];
  logic signed [angsp_pkg::DotW-1:0] d1_next [NA];
  logic signed [EW-1:0]              n1_next [NA][NA];

  always_comb begin
    logic signed [2*EW-1:0] pr;
    for (int k = 0; k < NA; k++) begin
      d1_next[k] = '0;
      for (int i = 0; i < NA; i++) begin
        n1_next[k][i] = r_in[i][(k == NA - 1) ? 0 : k + 1];
        pr = q[k][i] * n1_next[k][i];
        d1_next[k] = d1_next[k] + angsp_pkg::DotW'(pr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1 <= d1_next;
      n1 <= n1_next;
      w1 <= w_in;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: projection d * a_i, Q42 since d is Q28
  // --------------------------------------------------------------------------
  logic signed [angsp_pkg::ProjW-1:0] pj2 [NA][NA];
  logic signed [EW-1:0]               n2  [NA][NA];
  logic signed [EW-1:0]               w2  [NA];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < NA; k++) begin
        for (int i = 0; i < NA; i++) begin
          pj2[k][i] <= angsp_pkg::ProjW'(d1[k] * q[k][i]);
        end
      end
      n2 <= n1;
      w2 <= w1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: remainder m = n - round(proj >> 28), round half up
  // --------------------------------------------------------------------------
  logic signed [angsp_pkg::RemW-1:0] m3 [NA][NA];
  logic signed [EW-1:0]              w3 [NA];
  logic signed [angsp_pkg::RemW-1:0] m3_next [NA][NA];

  always_comb begin
    logic signed [angsp_pkg::ProjW-1:0] rs;
    for (int k = 0; k < NA; k++) begin
      for (int i = 0; i < NA; i++) begin
        rs = pj2[k][i] + angsp_pkg::ProjW'(48'sd1 <<< 27);
        m3_next[k][i] = angsp_pkg::RemW'(n2[k][i]) - $signed(rs[47:28]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      m3 <= m3_next;
      w3 <= w2;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: cross b x m with b = Q column k+1; both products per component
  // --------------------------------------------------------------------------
  logic signed [angsp_pkg::CrossW-1:0] cpa4 [NA][NA];  // [k][j]
  logic signed [angsp_pkg::CrossW-1:0] cpb4 [NA][NA];
  logic signed [EW-1:0]                w4   [NA];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < NA; k++) begin
        for (int j = 0; j < NA; j++) begin
          // component j: b[j+1]*m[j+2] - b[j+2]*m[j+1]
          cpa4[k][j] <= q[(k == NA - 1) ? 0 : k + 1][(j + 1) % NA] *
                        m3[k][(j + 2) % NA];
          cpb4[k][j] <= q[(k == NA - 1) ? 0 : k + 1][(j + 2) % NA] *
                        m3[k][(j + 1) % NA];
        end
      end
      w4 <= w3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: exact sum of the three crosses, Q28
  // --------------------------------------------------------------------------
  logic signed [angsp_pkg::SumW-1:0] s5 [NA];
  logic signed [EW-1:0]              w5 [NA];
  logic signed [angsp_pkg::SumW-1:0] s5_next [NA];

  always_comb begin
    for (int j = 0; j < NA; j++) begin
      s5_next[j] = '0;
      for (int k = 0; k < NA; k++) begin
        s5_next[j] = s5_next[j] + angsp_pkg::SumW'(cpa4[k][j])
                                - angsp_pkg::SumW'(cpb4[k][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5 <= s5_next;
      w5 <= w4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: stiffness * S as two partial products (sum split in halves),
  // damping * w
  // --------------------------------------------------------------------------
  logic        [angsp_pkg::SprLoW-1:0] plo6 [NA];
  logic signed [angsp_pkg::SprHiW-1:0] phi6 [NA];
  logic signed [angsp_pkg::DampPW-1:0] dp6  [NA];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int j = 0; j < NA; j++) begin
        plo6[j] <= stiffness * s5[j][angsp_pkg::SplitW-1:0];
        phi6[j] <= $signed({1'b0, stiffness}) *
                   $signed(s5[j][angsp_pkg::SumW-1:angsp_pkg::SplitW]);
        dp6[j]  <= $signed({1'b0, damping}) * w5[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: recombine and round both terms to Q8
  // --------------------------------------------------------------------------
  logic signed [angsp_pkg::SpringW-1:0] spr7 [NA];
  logic signed [angsp_pkg::DampW-1:0]   dmp7 [NA];
  logic signed [angsp_pkg::SpringW-1:0] spr7_next [NA];
  logic signed [angsp_pkg::DampW-1:0]   dmp7_next [NA];

  always_comb begin
    logic signed [63:0] full;
    logic signed [angsp_pkg::DampPW:0] dr;
    for (int j = 0; j < NA; j++) begin
      full = (64'(phi6[j]) <<< angsp_pkg::SplitW) +
             $signed(64'(plo6[j])) + (64'sd1 <<< 27);
      spr7_next[j] = full[63:28];
      dr = (angsp_pkg::DampPW+1)'(dp6[j]) + (angsp_pkg::DampPW+1)'(128);
      dmp7_next[j] = dr[angsp_pkg::DampPW:8];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      spr7 <= spr7_next;
      dmp7 <= dmp7_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: negate, add, saturate to 32 bits; this is the output register
  // --------------------------------------------------------------------------
  logic signed [angsp_pkg::MomentW-1:0] mom8 [NA];
  logic                                 sat8;
  logic signed [angsp_pkg::MomentW-1:0] mom8_next [NA];
  logic                                 sat8_next;

  always_comb begin
    logic signed [angsp_pkg::TotalW-1:0] tot;
    sat8_next = 1'b0;
    for (int j = 0; j < NA; j++) begin
      tot = -angsp_pkg::TotalW'(spr7[j]) - angsp_pkg::TotalW'(dmp7[j]);
      if (tot > angsp_pkg::TotalW'(64'sh7FFF_FFFF)) begin
        mom8_next[j] = 32'sh7FFF_FFFF;
        sat8_next    = 1'b1;
      end else if (tot < -angsp_pkg::TotalW'(64'sh8000_0000)) begin
        mom8_next[j] = 32'sh8000_0000;
        sat8_next    = 1'b1;
      end else begin
        mom8_next[j] = tot[angsp_pkg::MomentW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      mom8 <= mom8_next;
      sat8 <= sat8_next;
    end
  end

  assign m_axis_tvalid   = vld[NStage];
  assign m_axis_tdata    = {mom8[2], mom8[1], mom8[0]};
  assign m_axis_tuser[0] = sat8;

endmodule

### dv/angular_spring_restoring_moment_unit_test.sv
// ----------------------------------------------------------------------------
// angular_spring_restoring_moment_unit_test: self-checking bench
// Drives bodies (rotation + rate) through the stream input and checks every
// moment, field by field, against an in-bench fixed-point predictor. Covers
// reset values, unused register indexes, field extremes, saturation, rounding
// of halves and random configurations with bursty input and output stalls.
// ----------------------------------------------------------------------------
module angular_spring_restoring_moment_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NumAxes     = angsp_pkg::NumAxes;
  localparam int  EntryW      = angsp_pkg::EntryW;
  localparam int  MomentW     = angsp_pkg::MomentW;
  localparam int  InDataW     = angsp_pkg::InDataW;
  localparam int  OutDataW    = angsp_pkg::OutDataW;
  localparam int  CfgIndexW   = angsp_pkg::CfgIndexW;
  localparam int  CfgDataW    = angsp_pkg::CfgDataW;
  localparam int  ColW        = angsp_pkg::ColW;
  localparam int  CoefW       = angsp_pkg::CoefW;

  localparam int  ClkPeriod   = 4;
  localparam int  ResetCycles = 5;
  localparam int  TailCycles  = 20;    // idle cycles before the summary
  localparam int  IdleLimit   = 2000;  // cycles with no request, result or write
  localparam int  PhaseBodies = 200;
  localparam int  NumPhases   = 8;
  localparam int  ProdFrac    = 28;    // Q14 x Q14
  localparam int  CoefFrac    = 8;     // Q16.8 coefficient
  localparam int  MaxReports  = 10;
  localparam real Pi          = 3.14159265358979;
  localparam real HalfPi      = 1.57079632679490;
  localparam longint MomentMax = (longint'(1) << 31) - 1;
  localparam longint MomentMin = -(longint'(1) << 31);

  // one input request: rot[row][col] Q2.14, omega Q8.8
  typedef struct packed {
    logic [NumAxes-1:0][NumAxes-1:0][EntryW-1:0] rot;
    logic [NumAxes-1:0][EntryW-1:0]              omega;
  } body_t;

  // one result: Q24.8 moment and the clip flag
  typedef struct packed {
    logic [NumAxes-1:0][MomentW-1:0] moment;
    logic                            saturated;
  } moment_t;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  // predictor copy of the register file
  logic [ColW-1:0]  ref_cols [NumAxes];
  logic [CoefW-1:0] stiffness_q;
  logic [CoefW-1:0] damping_q;

  moment_t  moments_due[$];
  int       bodies_sent = 0;
  int       moments_checked = 0;
  int       clipped_seen = 0;
  int       reg_writes = 0;
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  angular_spring_restoring_moment_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // round to nearest, halves toward +inf; >>> on longint is a floor
  function automatic longint round_shift(longint x, int sh);
    return (x + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic moment_t predict_moment(body_t b);
    moment_t m;
    longint  r [NumAxes][NumAxes];
    longint  q [NumAxes][NumAxes];  // q[col][component]
    longint  s [NumAxes];
    longint  nv [NumAxes];
    longint  rem [NumAxes];
    longint  dot, w, spring, damp, total;
    int      i, k, nk;
    m = '0;
    for (i = 0; i < NumAxes; i++) begin
      s[i] = 0;
      for (k = 0; k < NumAxes; k++) begin
        r[i][k] = $signed(b.rot[i][k]);
        q[i][k] = $signed(ref_cols[i][EntryW*k +: EntryW]);
      end
    end
    // per axis: next column of R, minus its projection on ref column k,
    // crossed with ref column k+1
    for (k = 0; k < NumAxes; k++) begin
      nk  = (k + 1) % NumAxes;
      dot = 0;
      for (i = 0; i < NumAxes; i++) begin
        nv[i] = r[i][nk];
        dot  += q[k][i] * nv[i];
      end
      for (i = 0; i < NumAxes; i++)
        rem[i] = nv[i] - round_shift(dot * q[k][i], ProdFrac);
      s[0] += q[nk][1] * rem[2] - q[nk][2] * rem[1];
      s[1] += q[nk][2] * rem[0] - q[nk][0] * rem[2];
      s[2] += q[nk][0] * rem[1] - q[nk][1] * rem[0];
    end
    for (i = 0; i < NumAxes; i++) begin
      w      = $signed(b.omega[i]);
      spring = round_shift(longint'(stiffness_q) * s[i], ProdFrac);
      damp   = round_shift(longint'(damping_q) * w, CoefFrac);
      total  = -spring - damp;
      if (total > MomentMax) begin
        total = MomentMax;
        m.saturated = 1'b1;
      end else if (total < MomentMin) begin
        total = MomentMin;
        m.saturated = 1'b1;
      end
      m.moment[i] = total[MomentW-1:0];
    end
    return m;
  endfunction

  // ---------------------------------------------------------------- body makers

  // R = Rz(yaw) * Ry(pitch) * Rx(roll), rounded to Q2.14, omega zero
  function automatic body_t euler_body(real yaw, real pitch, real roll);
    body_t b;
    real   ca, sa, cb, sb, cc, sc;
    real   m [NumAxes][NumAxes];
    int    i, k;
    ca = $cos(yaw);   sa = $sin(yaw);
    cb = $cos(pitch); sb = $sin(pitch);
    cc = $cos(roll);  sc = $sin(roll);
    m[0][0] = ca * cb; m[0][1] = ca * sb * sc - sa * cc; m[0][2] = ca * sb * cc + sa * sc;
    m[1][0] = sa * cb; m[1][1] = sa * sb * sc + ca * cc; m[1][2] = sa * sb * cc - ca * sc;
    m[2][0] = -sb;     m[2][1] = cb * sc;                m[2][2] = cb * cc;
    b = '0;
    for (i = 0; i < NumAxes; i++)
      for (k = 0; k < NumAxes; k++)
        b.rot[i][k] = EntryW'(int'(16384.0 * m[i][k]));
    return b;
  endfunction

  function automatic body_t uniform_body(logic [EntryW-1:0] rv, logic [EntryW-1:0] wv);
    body_t b;
    int    i, k;
    for (i = 0; i < NumAxes; i++) begin
      b.omega[i] = wv;
      for (k = 0; k < NumAxes; k++)
        b.rot[i][k] = rv;
    end
    return b;
  endfunction

  function automatic real random_angle(real span);
    return (real'($urandom_range(0, 20000)) / 10000.0 - 1.0) * span;
  endfunction

  function automatic body_t random_body();
    body_t b;
    int    kind, i, k;
    kind = $urandom_range(0, 3);
    case (kind)
      0: b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      1: begin
        // proper rotation with a little noise on the entries
        b = euler_body(random_angle(Pi), random_angle(Pi), random_angle(Pi));
        for (i = 0; i < NumAxes; i++)
          for (k = 0; k < NumAxes; k++)
            b.rot[i][k] = b.rot[i][k] + EntryW'($urandom_range(0, 6)) - EntryW'(3);
      end
      2: begin
        for (i = 0; i < NumAxes; i++)
          for (k = 0; k < NumAxes; k++)
            b.rot[i][k] = EntryW'(int'($urandom_range(0, 32768)) - 16384);
      end
      default: b = euler_body(random_angle(0.3), random_angle(0.3), random_angle(0.3));
    endcase
    if (kind != 0)
      for (i = 0; i < NumAxes; i++)
        b.omega[i] = $urandom_range(0, 1) ? EntryW'($urandom)
                                          : EntryW'(int'($urandom_range(0, 2048)) - 1024);
    return b;
  endfunction

  function automatic logic [CoefW-1:0] random_coef();
    case ($urandom_range(0, 3))
      0:       return CoefW'($urandom);
      1:       return CoefW'($urandom_range(0, 1024));
      2:       return '1;
      default: return CoefW'($urandom_range(0, 64));
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  // one register write; unused indexes leave the predictor alone
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      angsp_pkg::CFG_REF_COL_X: ref_cols[0] = val[ColW-1:0];
      angsp_pkg::CFG_REF_COL_Y: ref_cols[1] = val[ColW-1:0];
      angsp_pkg::CFG_REF_COL_Z: ref_cols[2] = val[ColW-1:0];
      angsp_pkg::CFG_STIFFNESS: stiffness_q = val[CoefW-1:0];
      angsp_pkg::CFG_DAMPING:   damping_q   = val[CoefW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // coefficients go out with junk in the unused upper bits
  task automatic apply_config(input logic [ColW-1:0] cx, input logic [ColW-1:0] cy,
                              input logic [ColW-1:0] cz, input logic [CoefW-1:0] k,
                              input logic [CoefW-1:0] d);
    write_reg(angsp_pkg::CFG_REF_COL_X, cx);
    write_reg(angsp_pkg::CFG_REF_COL_Y, cy);
    write_reg(angsp_pkg::CFG_REF_COL_Z, cz);
    write_reg(angsp_pkg::CFG_STIFFNESS, {(CfgDataW - CoefW)'($urandom), k});
    write_reg(angsp_pkg::CFG_DAMPING,   {(CfgDataW - CoefW)'($urandom), d});
  endtask

  // present one request and hold it until taken; valid stays high afterwards
  task automatic send_body(input body_t b);
    logic [InDataW-1:0] word;
    int                 i, k;
    for (i = 0; i < NumAxes; i++) begin
      word[EntryW*(NumAxes*NumAxes + i) +: EntryW] = b.omega[i];
      for (k = 0; k < NumAxes; k++)
        word[EntryW*(i*NumAxes + k) +: EntryW] = b.rot[i][k];
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
    moments_due.push_back(predict_moment(b));
    bodies_sent++;
  endtask

  // bursts of random length with random gaps, sometimes none
  task automatic send_paced(input body_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_body(b);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (moments_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  // reset leaves stiffness and damping at zero: every moment is zero
  task automatic test_reset_state();
    send_body(uniform_body(16'h8000, 16'h8000));
    send_body(random_body());
    wait_drained();
  endtask

  // writes to indexes past the last register must change nothing
  task automatic test_unused_index();
    int idx;
    apply_config(angsp_pkg::RefColXReset, angsp_pkg::RefColYReset,
                 angsp_pkg::RefColZReset, 24'd256, 24'd256);
    for (idx = int'(angsp_pkg::CFG_DAMPING) + 1; idx < (1 << CfgIndexW); idx++)
      write_reg(CfgIndexW'(idx), CfgDataW'({$urandom, $urandom}));
    send_body(euler_body(0.4, -0.2, 0.7));
    send_body(random_body());
    wait_drained();
  endtask

  // unit coefficients, identity reference, field extremes
  task automatic test_field_extremes();
    body_t b;
    int    i, k;
    send_body(euler_body(0.0, 0.0, 0.0));
    b = euler_body(0.0, 0.0, 0.0);
    b.omega[0] = 16'h7FFF; b.omega[1] = 16'h8000; b.omega[2] = 16'h0001;
    send_body(b);
    send_body(uniform_body(16'h4000, 16'h0000));
    send_body(uniform_body(16'hC000, 16'h0100));
    send_body(uniform_body(16'h8000, 16'h8000));
    send_body(uniform_body(16'h7FFF, 16'h7FFF));
    send_body(euler_body(HalfPi, 0.0, 0.0));
    // checkerboard of 0101/1010 patterns
    b = uniform_body(16'h5555, 16'hAAAA);
    for (i = 0; i < NumAxes; i++)
      for (k = 0; k < NumAxes; k++)
        if ((i + k) % 2 != 0) b.rot[i][k] = 16'hAAAA;
    b.omega[1] = 16'h5555;
    send_body(b);
    send_body(uniform_body(16'h0000, 16'h0000));
    wait_drained();
  endtask

  // full-scale coefficients clip both ways; then tiny ones hit rounding halves
  task automatic test_clip_and_round();
    body_t b;
    apply_config(angsp_pkg::RefColXReset, angsp_pkg::RefColYReset,
                 angsp_pkg::RefColZReset, '1, '1);
    send_body(uniform_body(16'h8000, 16'h8000));
    send_body(uniform_body(16'h7FFF, 16'h7FFF));
    send_body(euler_body(0.0, 0.0, HalfPi));
    b = euler_body(0.0, Pi, 0.0);
    b.omega[0] = 16'h8000; b.omega[1] = 16'h7FFF; b.omega[2] = 16'h0000;
    send_body(b);
    wait_drained();
    // damping of 1/256 on omega of +-128: exact halves
    apply_config(angsp_pkg::RefColXReset, angsp_pkg::RefColYReset,
                 angsp_pkg::RefColZReset, 24'd1, 24'd1);
    b = euler_body(HalfPi, 0.0, 0.0);
    b.omega[0] = 16'sd128; b.omega[1] = -16'sd128; b.omega[2] = 16'sd384;
    send_body(b);
    b.omega[0] = -16'sd384; b.omega[1] = 16'sd127; b.omega[2] = -16'sd129;
    send_body(b);
    wait_drained();
  endtask

  // one setting per phase, extremes first, then random ones
  task automatic test_random_phases();
    logic [ColW-1:0]  cols [NumAxes];
    logic [CoefW-1:0] k, d;
    body_t            rb;
    int               p, n, c;
    for (p = 0; p < NumPhases; p++) begin
      wait_drained();
      case (p)
        0: begin
          cols[0] = angsp_pkg::RefColXReset; cols[1] = angsp_pkg::RefColYReset;
          cols[2] = angsp_pkg::RefColZReset;
          k = 24'd256; d = 24'd256;
        end
        1: begin
          cols[0] = angsp_pkg::RefColXReset; cols[1] = angsp_pkg::RefColYReset;
          cols[2] = angsp_pkg::RefColZReset;
          k = '1; d = '1;
        end
        2: begin
          cols[0] = '0; cols[1] = '0; cols[2] = '0;
          k = '1; d = '0;
        end
        3: begin
          cols[0] = '1; cols[1] = '1; cols[2] = '1;
          k = random_coef(); d = random_coef();
        end
        4: begin
          // most negative entry everywhere
          cols[0] = 48'h8000_8000_8000; cols[1] = 48'h8000_8000_8000;
          cols[2] = 48'h8000_8000_8000;
          k = 24'd1; d = 24'd1;
        end
        default: begin
          rb = euler_body(random_angle(Pi), random_angle(Pi), random_angle(Pi));
          for (c = 0; c < NumAxes; c++)
            cols[c] = $urandom_range(0, 1) ? {rb.rot[2][c], rb.rot[1][c], rb.rot[0][c]}
                                           : ColW'({$urandom, $urandom});
          k = random_coef(); d = random_coef();
        end
      endcase
      apply_config(cols[0], cols[1], cols[2], k, d);
      burst_left = 0;
      for (n = 0; n < PhaseBodies; n++) begin
        // odd phases stop halfway and let the pipe empty out
        if (p % 2 == 1 && n == PhaseBodies / 2) wait_drained();
        send_paced(random_body());
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------- receiver

  // stall pattern: long stretches that are open, choppy or mostly blocked
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
      default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // each accepted result against the oldest pending prediction
  always @(posedge clk) begin
    moment_t got, want;
    logic    bad;
    int      i;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      for (i = 0; i < NumAxes; i++)
        got.moment[i] = m_axis_tdata[MomentW*i +: MomentW];
      got.saturated = m_axis_tuser[0];
      moments_checked++;
      if (got.saturated === 1'b1) clipped_seen++;
      if (moments_due.size() == 0) begin
        if (mismatches < MaxReports)
          $display("result with no request pending: x=%0d y=%0d z=%0d sat=%0b",
                   $signed(got.moment[0]), $signed(got.moment[1]),
                   $signed(got.moment[2]), got.saturated);
        mismatches++;
      end else begin
        want = moments_due.pop_front();
        bad  = (got.saturated !== want.saturated);
        for (i = 0; i < NumAxes; i++)
          if (got.moment[i] !== want.moment[i]) bad = 1'b1;
        if (bad) begin
          if (mismatches < MaxReports)
            $display("moment %0d mismatch: want x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
                     moments_checked, $signed(want.moment[0]), $signed(want.moment[1]),
                     $signed(want.moment[2]), want.saturated, $signed(got.moment[0]),
                     $signed(got.moment[1]), $signed(got.moment[2]), got.saturated);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long with no request, result or register write
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: %0d idle cycles, %0d results outstanding",
               idle_cycles, moments_due.size());
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    ref_cols[0] = angsp_pkg::RefColXReset;
    ref_cols[1] = angsp_pkg::RefColYReset;
    ref_cols[2] = angsp_pkg::RefColZReset;
    stiffness_q = '0;
    damping_q   = '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_unused_index();
    test_field_extremes();
    test_clip_and_round();
    test_random_phases();

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    $display("summary: %0d bodies sent, %0d moments checked (%0d clipped), %0d register writes",
             bodies_sent, moments_checked, clipped_seen, reg_writes);
    $display("summary: %0d mismatches over %0d configuration phases", mismatches, NumPhases);
    if (mismatches == 0 && moments_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/angsp_pkg.sv
hw/rtl/angular_spring_restoring_moment_unit.sv
dv/angular_spring_restoring_moment_unit_test.sv
